// ===== hdl/tcf_pkg.sv =====
package tcf_pkg;

	// Telnet protocol bytes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_AYT  = 8'd246;
	localparam logic [7:0] TN_AO   = 8'd245;
	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;

	// Result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Job codes passed from front to back
	localparam logic [2:0] JOB_DATA   = 3'd0;
	localparam logic [2:0] JOB_ABORT  = 3'd1;
	localparam logic [2:0] JOB_ERROR  = 3'd2;
	localparam logic [2:0] JOB_ANSWER = 3'd3;
	localparam logic [2:0] JOB_GREET  = 3'd4;

	// Parser byte counts
	localparam logic [1:0] CNT_IDLE = 2'd0;
	localparam logic [1:0] CNT_OP   = 2'd1;
	localparam logic [1:0] CNT_OPT  = 2'd2;

	// Words per input are capped at this
	localparam int MAX_RESULTS = 24;
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int GREET_IDX_W = 6;

	// Job queue depth
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic REG_COMMAND_SUPPORT = 1'b0;
	localparam logic REG_ECHO_CHANGE_OK  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} tcf_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
		logic       echo_now;
		logic       muted_now;
	} tcf_out_t;

	typedef struct packed {
		logic [2:0] job;
		logic [7:0] value;
		logic       will;
		logic       echo_now;
		logic       muted_now;
	} tcf_job_t;

	typedef struct packed {
		logic command_support;
		logic echo_change_ok;
	} tcf_cfg_t;

	// Commands that carry an option byte
	function automatic logic is_long_cmd(input logic [7:0] code);
		return (code == TN_SB) || (code == TN_WILL) || (code == TN_WONT) ||
			(code == TN_DO) || (code == TN_DONT);
	endfunction

	// Greeting text sent for are-you-there
	function automatic logic [7:0] greet_byte(input logic [GREET_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:  b = 8'h5A;
			6'd1:  b = 8'h65;
			6'd2:  b = 8'h70;
			6'd3:  b = 8'h68;
			6'd4:  b = 8'h79;
			6'd5:  b = 8'h72;
			6'd6:  b = 8'h20;
			6'd7:  b = 8'h61;
			6'd8:  b = 8'h74;
			6'd9:  b = 8'h20;
			6'd10: b = 8'h79;
			6'd11: b = 8'h6F;
			6'd12: b = 8'h75;
			6'd13: b = 8'h72;
			6'd14: b = 8'h20;
			6'd15: b = 8'h73;
			6'd16: b = 8'h65;
			6'd17: b = 8'h72;
			6'd18: b = 8'h76;
			6'd19: b = 8'h69;
			6'd20: b = 8'h63;
			6'd21: b = 8'h65;
			6'd22: b = 8'h0D;
			6'd23: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/tcf_front.sv =====
module tcf_front import tcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tcf_cfg_t cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  tcf_in_t  in_data,
	input  logic     q_full,
	output logic     push,
	output tcf_job_t push_job
);

	logic [1:0] cnt_q, cnt_d;
	logic [7:0] code_q, code_d;
	logic       echo_q, echo_d;
	logic       muted_q, muted_d;
	logic       need_push;
	logic       accept;
	logic [7:0] b;

	assign b        = in_data.rx_byte;
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && need_push;

	// Parser and command decode
	always_comb begin
		cnt_d     = cnt_q;
		code_d    = code_q;
		echo_d    = echo_q;
		muted_d   = muted_q;
		need_push = 1'b0;
		push_job  = '0;
		if (in_data.op) begin
			cnt_d   = CNT_IDLE;
			code_d  = 8'd0;
			muted_d = 1'b0;
			echo_d  = 1'b0;
		end else if (cnt_q == CNT_OP) begin
			code_d = b;
			cnt_d  = CNT_OPT;
			if (!is_long_cmd(b)) begin
				cnt_d  = CNT_IDLE;
				code_d = 8'd0;
				if (cfg.command_support) begin
					if (b == TN_AO) begin
						muted_d      = 1'b1;
						need_push    = 1'b1;
						push_job.job = JOB_ABORT;
					end else if (b == TN_AYT) begin
						need_push    = 1'b1;
						push_job.job = JOB_GREET;
					end
				end
			end
		end else if (cnt_q == CNT_OPT) begin
			cnt_d  = CNT_IDLE;
			code_d = 8'd0;
			if (cfg.command_support && code_q == TN_DO) begin
				need_push      = 1'b1;
				push_job.job   = JOB_ANSWER;
				push_job.value = b;
				push_job.will  = (b == OPT_SGA) || (b == OPT_ECHO && cfg.echo_change_ok);
				if (b == OPT_ECHO && cfg.echo_change_ok)
					echo_d = 1'b1;
			end else if (cfg.command_support && code_q == TN_DONT) begin
				need_push      = 1'b1;
				push_job.job   = JOB_ANSWER;
				push_job.value = b;
				push_job.will  = (b == OPT_ECHO) && !cfg.echo_change_ok;
				if (b == OPT_ECHO && cfg.echo_change_ok)
					echo_d = 1'b0;
			end else if (code_q == TN_SB) begin
				// peer is dropped: error close, mute released
				need_push    = 1'b1;
				push_job.job = JOB_ERROR;
				muted_d      = 1'b0;
			end
		end else begin
			if (b == TN_IAC) begin
				cnt_d = CNT_OP;
			end else begin
				cnt_d          = CNT_IDLE;
				need_push      = 1'b1;
				push_job.job   = JOB_DATA;
				push_job.value = b;
			end
		end
		push_job.echo_now  = echo_d;
		push_job.muted_now = muted_d;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= CNT_IDLE;
			code_q  <= 8'd0;
			echo_q  <= 1'b0;
			muted_q <= 1'b0;
		end else if (accept) begin
			cnt_q   <= cnt_d;
			code_q  <= code_d;
			echo_q  <= echo_d;
			muted_q <= muted_d;
		end
	end

endmodule

// ===== hdl/tcf_queue.sv =====
module tcf_queue import tcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tcf_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output tcf_job_t head
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);

	tcf_job_t         mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    cnt_q;

	assign full  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/tcf_back.sv =====
module tcf_back import tcf_pkg::*; #(
	parameter int GREETING_LEN = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  tcf_job_t head,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output tcf_out_t out_data
);

	localparam int GreetCount = (GREETING_LEN > MAX_RESULTS) ? MAX_RESULTS : GREETING_LEN;
	localparam logic [IDX_W-1:0] GreetLast = IDX_W'(GreetCount - 1);
	localparam logic [IDX_W-1:0] AnswerLast = IDX_W'(2);

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	tcf_out_t         data_q;
	logic             load;
	logic             fin;
	tcf_out_t         word;

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign load      = (!valid_q || out_ready) && !q_empty;
	assign pop       = load && fin;

	// Expand head job into its current word
	always_comb begin
		word           = '0;
		word.echo_now  = head.echo_now;
		word.muted_now = head.muted_now;
		fin            = 1'b1;
		case (head.job)
			JOB_DATA: begin
				word.kind  = KIND_DATA;
				word.value = head.value;
			end
			JOB_ABORT: word.kind = KIND_ABORT;
			JOB_ERROR: word.kind = KIND_ERROR;
			JOB_ANSWER: begin
				word.kind = KIND_REPLY;
				fin       = (idx_q == AnswerLast);
				case (idx_q)
					IDX_W'(0): word.value = TN_IAC;
					IDX_W'(1): word.value = head.will ? TN_WILL : TN_WONT;
					default:   word.value = head.value;
				endcase
			end
			JOB_GREET: begin
				word.kind  = KIND_REPLY;
				word.value = greet_byte({{(GREET_IDX_W-IDX_W){1'b0}}, idx_q});
				fin        = (idx_q == GreetLast);
			end
			default: word.kind = KIND_ERROR;
		endcase
		word.last = fin;
	end

	// Word index within job, output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= fin ? '0 : idx_q + 1'b1;
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (load)
			data_q <= word;
	end

endmodule

// ===== hdl/telnet_command_filter.sv =====
// Telnet receive-side command filter.
// Input channel (in_valid/in_ready/in_data) takes one word per cycle while
// the queue has room: a received byte (op = 0) or a connect marker
// (op = 1). Output channel (out_valid/out_ready/out_data) gives the result
// words: data bytes for the shell, reply bytes for the client, abort-output
// and error-close marks. The final word caused by one input has last set.
// A front parser decodes IAC commands and pushes one job per input that
// has results into a four-entry queue; a back expander turns each job into
// its words through a registered output stage.
// The first word of an input passes through the queue and then the output
// register. One input is taken per cycle while the queue has room; the back
// end sends one word per cycle while a job waits and out_ready is high, so a
// DO/DONT answer is 3 words and a greeting min(GREETING_LEN, 24) words,
// during which the queue absorbs further inputs. When out_ready is low the
// output word holds and in_ready drops once the queue is full.
// Reset clears the parser, echo, mute, queue and output stage; both
// configuration registers reset to 1. Registers: 0x0 command_support,
// 0x4 echo_change_ok, bit 0, over the APB port.
module telnet_command_filter import tcf_pkg::*; #(
	parameter int GREETING_LEN = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  tcf_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output tcf_out_t    out_data
);

	tcf_cfg_t cfg_q;
	logic     wr_en;
	logic     push, pop, q_full, q_empty;
	tcf_job_t push_job, head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_support <= 1'b1;
			cfg_q.echo_change_ok  <= 1'b1;
		end else if (wr_en) begin
			if (paddr[2] == REG_COMMAND_SUPPORT)
				cfg_q.command_support <= pwdata[0];
			else
				cfg_q.echo_change_ok <= pwdata[0];
		end
	end

	// Register readback
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_ECHO_CHANGE_OK)
			prdata[0] = cfg_q.echo_change_ok;
		else
			prdata[0] = cfg_q.command_support;
	end

	tcf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	tcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	tcf_back #(
		.GREETING_LEN (GREETING_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
